@@ src/u2h_pkg.sv @@
// ----------------------------------------------------------------------------
// u2h_pkg
// Shared types, constants and helpers of the UTF-8 to UCS-2 hex converter.
// ----------------------------------------------------------------------------
package u2h_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] ReplacementCp = 16'h003F;
  localparam logic [7:0]  AsciiLimit    = 8'h80;

  // One queue entry: one or two code points out of a single input byte.
  // The second code point only appears when a three-byte sequence is cut
  // short by the end of text, and it is then below 0x80.
  typedef struct packed {
    logic [15:0] cp0;
    logic [6:0]  cp1;
    logic        two;
    logic        last;
  } entry_t;

  function automatic logic is_lead2(input logic [7:0] b);
    return (b & 8'hE0) == 8'hC0;
  endfunction

  function automatic logic is_lead3(input logic [7:0] b);
    return (b & 8'hF0) == 8'hE0;
  endfunction

  function automatic logic [6:0] hex_ascii(input logic [3:0] n);
    logic [6:0] r;
    if (n < 4'd10) begin
      r = 7'h30 + {3'b000, n};
    end else begin
      r = 7'h37 + {3'b000, n};
    end
    return r;
  endfunction

endpackage

@@ src/u2h_fifo.sv @@
// ----------------------------------------------------------------------------
// u2h_fifo
// Small register queue of decoded code points between decoder and serialiser.
// ----------------------------------------------------------------------------
module u2h_fifo import u2h_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ src/u2h_front.sv @@
// ----------------------------------------------------------------------------
// u2h_front
// Byte decoder: holds lead bytes until their followers arrive and pushes
// complete code points, or replacements for bad bytes, towards the queue.
// ----------------------------------------------------------------------------
module u2h_front import u2h_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // in_byte
  input  logic       s_tlast_i,   // end_of_text
  input  logic       full_i,
  output logic       push_o,
  output entry_t     entry_o
);

  logic [7:0] held_lead_q, held_lead_d;
  logic [7:0] held_second_q, held_second_d;
  logic [1:0] held_count_q, held_count_d;
  logic       accept;
  logic       push;
  entry_t     entry;
  logic [7:0] b;
  logic       eot;

  assign s_tready_o = !full_i;
  assign accept     = s_tvalid_i && !full_i;
  assign b          = s_tdata_i;
  assign eot        = s_tlast_i;

  always_comb begin
    held_lead_d   = held_lead_q;
    held_second_d = held_second_q;
    held_count_d  = 2'd0;
    push          = 1'b0;
    entry.cp0     = ReplacementCp;
    entry.cp1     = ReplacementCp[6:0];
    entry.two     = 1'b0;
    entry.last    = eot;
    case (held_count_q)
      2'd1: begin
        if (is_lead2(held_lead_q)) begin
          push      = 1'b1;
          entry.cp0 = {5'd0, held_lead_q[4:0], b[5:0]};
        end else if (eot) begin
          // three-byte lead cut short: replacement, then the byte on its own
          push      = 1'b1;
          entry.two = 1'b1;
          if (b < AsciiLimit) begin
            entry.cp1 = b[6:0];
          end
        end else begin
          held_second_d = b;
          held_count_d  = 2'd2;
        end
      end
      2'd2: begin
        push      = 1'b1;
        entry.cp0 = {held_lead_q[3:0], held_second_q[5:0], b[5:0]};
      end
      default: begin
        if (b < AsciiLimit) begin
          push      = 1'b1;
          entry.cp0 = {8'd0, b};
        end else if (is_lead2(b) || is_lead3(b)) begin
          if (eot) begin
            push = 1'b1;
          end else begin
            held_lead_d  = b;
            held_count_d = 2'd1;
          end
        end else begin
          push = 1'b1;
        end
      end
    endcase
    if (eot) begin
      held_lead_d   = '0;
      held_second_d = '0;
      held_count_d  = 2'd0;
    end
  end

  assign push_o  = accept && push;
  assign entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_lead_q   <= '0;
      held_second_q <= '0;
      held_count_q  <= '0;
    end else if (accept) begin
      held_lead_q   <= held_lead_d;
      held_second_q <= held_second_d;
      held_count_q  <= held_count_d;
    end
  end

endmodule

@@ src/u2h_back.sv @@
// ----------------------------------------------------------------------------
// u2h_back
// Serialiser: turns each queued code point into four hex characters, one per
// cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module u2h_back import u2h_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  entry_t     entry_i,
  output logic       pop_o,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,   // hex_char, bit 7 zero
  output logic       m_tlast_o    // last_char
);

  logic        busy_q;
  logic [2:0]  step_q;
  logic [31:0] word_q;
  logic        two_q;
  logic        last_q;
  logic        out_valid_q;
  logic [6:0]  out_char_q;
  logic        out_last_q;
  logic        load_out, emit, final_char, pop;

  assign load_out   = !out_valid_q || m_tready_i;
  assign emit       = busy_q && load_out;
  assign final_char = (step_q == (two_q ? 3'd7 : 3'd3));
  // refill in the same cycle as the final character is loaded into the output stage
  assign pop        = valid_i && (!busy_q || (emit && final_char));
  assign pop_o      = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (emit && final_char) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        step_q <= step_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      word_q <= {entry_i.cp0, 9'd0, entry_i.cp1};
      two_q  <= entry_i.two;
      last_q <= entry_i.last;
    end else if (emit) begin
      word_q <= {word_q[27:0], 4'd0};
    end
    if (emit) begin
      out_char_q <= hex_ascii(word_q[31:28]);
      out_last_q <= last_q && final_char;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {1'b0, out_char_q};
  assign m_tlast_o  = out_last_q;

endmodule

@@ src/utf8_to_ucs2_hex_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_to_ucs2_hex_unit
// UTF-8 byte stream in, uppercase hex UCS-2 characters out.
//
//   channel  dir  tdata                  tlast
//   s_       in   in_byte [7:0]          end_of_text
//   m_       out  hex_char [6:0], 0 [7]  last_char
//
// One hex character leaves per cycle while the receiver is ready; a code point
// becomes four hex characters in the serialiser, so ASCII text is limited by the
// output stage. Lead bytes are held and give no output until their sequence ends.
// Reset clears held bytes, the queue and the output stage. Either side may
// stall; the queue lets the decoder run ahead until it is full.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_hex_unit import u2h_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // [7:0] in_byte
  input  logic       s_tlast_i,   // end_of_text
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,   // [6:0] hex_char, [7] zero
  output logic       m_tlast_o    // last_char
);

  logic   push, full, pop, q_valid;
  entry_t push_entry, pop_entry;

  u2h_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  u2h_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  u2h_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .entry_i    (pop_entry),
    .pop_o      (pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_to_ucs2_hex_unit. Drives UTF-8 bytes on the
// slave stream and checks every hex character on the master stream against
// an in-bench decoder. A short table of hand-picked bytes runs first. Random
// texts of well-formed, truncated and stray sequences follow, under three
// idling regimes, with one long output stall and one drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import u2h_pkg::*;

  localparam int NumDirected = 25;
  localparam int NumRandom   = 336;

  // held bytes in the decoder
  localparam logic [1:0] HeldNone = 2'd0;
  localparam logic [1:0] HeldLead = 2'd1;
  localparam logic [1:0] HeldTwo  = 2'd2;

  // {byte, end of text, typed, code point count, cp0, cp1}
  typedef struct packed {
    logic [7:0]  b;
    logic        eot;
    logic        typed;
    logic [1:0]  n;
    logic [15:0] cp0;
    logic [15:0] cp1;
  } stim_row_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } hex_char_t;

  localparam stim_row_t DirectedRows [NumDirected] = '{
    {8'h00, 1'b0, 1'b1, 2'd1, 16'h0000, 16'h0000},  // reset, lowest byte
    {8'h7F, 1'b0, 1'b1, 2'd1, 16'h007F, 16'h0000},
    {8'hC3, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hA9, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hDF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hE2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'h82, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hAC, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hEF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hBF, 1'b0, 1'b1, 2'd1, 16'hFFFF, 16'h0000},  // largest code point
    {8'h80, 1'b0, 1'b1, 2'd1, 16'h003F, 16'h0000},  // stray follower
    {8'hF0, 1'b0, 1'b1, 2'd1, 16'h003F, 16'h0000},  // four-byte lead
    {8'hFF, 1'b0, 1'b1, 2'd1, 16'h003F, 16'h0000},
    {8'hC2, 1'b1, 1'b1, 2'd1, 16'h003F, 16'h0000},  // text ends at a lead
    {8'hE0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'h41, 1'b1, 1'b1, 2'd2, 16'h003F, 16'h0041},  // cut inside 3-byte
    {8'hE5, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hC3, 1'b1, 1'b1, 2'd2, 16'h003F, 16'h003F},  // cut, then lone lead
    {8'hC0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'h00, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hE0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'h7F, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'h55, 1'b1, 1'b0, 2'd0, 16'h0000, 16'h0000}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  utf8_to_ucs2_hex_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tlast_i  (s_tlast),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tlast_o  (m_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // decoder state
  logic [7:0]  lead_q = 8'h00;
  logic [7:0]  second_q = 8'h00;
  logic [1:0]  held_q = HeldNone;
  logic [15:0] dec_cp [2];
  int          dec_n;

  hex_char_t expected_chars [$];
  int errors = 0;
  int bytes_sent = 0;
  int chars_checked = 0;
  int texts_ended = 0;
  int tx_idle_pct = 25;
  int rx_idle_pct = 45;
  int rx_hold_req = 0;

  function automatic logic [6:0] nibble_char(input logic [3:0] nib);
    return (nib < 4'd10) ? 7'h30 + 7'(nib) : 7'h41 + 7'(nib) - 7'd10;
  endfunction

  function automatic void add_cp(input logic [15:0] cp);
    dec_cp[dec_n] = cp;
    dec_n++;
  endfunction

  // byte seen with nothing held
  function automatic void decode_alone(input logic [7:0] b, input logic eot);
    if (!b[7]) begin
      add_cp({8'h00, b});
    end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110) begin
      if (eot) begin
        add_cp(ReplacementCp);
      end else begin
        lead_q = b;
        held_q = HeldLead;
      end
    end else begin
      add_cp(ReplacementCp);
    end
  endfunction

  function automatic void transcode_byte(input logic [7:0] b, input logic eot);
    dec_n = 0;
    case (held_q)
      HeldLead: begin
        held_q = HeldNone;
        if (lead_q[7:5] == 3'b110) begin
          add_cp({5'b00000, lead_q[4:0], b[5:0]});
        end else if (eot) begin
          add_cp(ReplacementCp);
          decode_alone(b, 1'b1);
        end else begin
          second_q = b;
          held_q = HeldTwo;
        end
      end
      HeldTwo: begin
        held_q = HeldNone;
        add_cp({lead_q[3:0], second_q[5:0], b[5:0]});
      end
      default: begin
        held_q = HeldNone;
        decode_alone(b, eot);
      end
    endcase
    if (eot) begin
      lead_q = 8'h00;
      second_q = 8'h00;
      held_q = HeldNone;
    end
  endfunction

  // last flag only on the final character of an end-of-text transaction
  function automatic void queue_code_points(input int n, input logic [15:0] cp0,
                                            input logic [15:0] cp1, input logic eot);
    logic [15:0] cp;
    for (int i = 0; i < n; i++) begin
      cp = (i == 0) ? cp0 : cp1;
      for (int k = 0; k < 4; k++) begin
        expected_chars.push_back({nibble_char(cp[15 - 4 * k -: 4]),
                                  eot && i == n - 1 && k == 3});
      end
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eot;
    do @(posedge clk_i); while (!s_tready);
    bytes_sent++;
    if (eot) texts_ended++;
  endtask

  task automatic send_predicted(input logic [7:0] b, input logic eot);
    send_item(b, eot);
    transcode_byte(b, eot);
    queue_code_points(dec_n, dec_cp[0], dec_cp[1], eot);
  endtask

  function automatic logic [7:0] follower_byte();
    return ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                    : {2'b10, 6'($urandom_range(63))};
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (rx_hold_req != holds_done) begin
        holds_done = rx_hold_req;
        hold_left = 200;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    hex_char_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected hex character %h (last %b)", m_tdata, m_tlast);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (m_tdata[6:0] !== want.ch) begin
          $error("hex_char: expected %h, got %h", want.ch, m_tdata[6:0]);
          errors++;
        end
        if (m_tdata[7] !== 1'b0) begin
          $error("tdata pad: expected 0, got %b", m_tdata[7]);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last_char: expected %b, got %b", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    logic [7:0] seq [3];
    int seq_len;
    int cut_len;
    int sent_random;
    int pick;
    logic eot;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      row = DirectedRows[i];
      send_item(row.b, row.eot);
      transcode_byte(row.b, row.eot);
      if (row.typed) begin
        queue_code_points(row.n, row.cp0, row.cp1, row.eot);
      end else begin
        queue_code_points(dec_n, dec_cp[0], dec_cp[1], row.eot);
      end
    end

    sent_random = 0;
    while (sent_random < NumRandom) begin
      if (sent_random >= 120 && tx_idle_pct == 25) begin
        tx_idle_pct = 45;
        rx_idle_pct = 25;
        rx_hold_req++;  // sender keeps offering so the queue backs up
      end else if (sent_random >= 240 && tx_idle_pct == 45) begin
        s_tvalid <= 1'b0;
        @(posedge clk_i);
        while (expected_chars.size() != 0) @(posedge clk_i);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      pick = $urandom_range(99);
      if (pick < 35) begin
        seq[0] = {1'b0, 7'($urandom_range(127))};
        seq_len = 1;
      end else if (pick < 55) begin
        seq[0] = {3'b110, 5'($urandom_range(31))};
        seq[1] = follower_byte();
        seq_len = 2;
      end else if (pick < 75) begin
        seq[0] = {4'b1110, 4'($urandom_range(15))};
        seq[1] = follower_byte();
        seq[2] = follower_byte();
        seq_len = 3;
      end else if (pick < 85) begin
        seq[0] = $urandom_range(1) ? {2'b10, 6'($urandom_range(63))}
                                   : {4'b1111, 4'($urandom_range(15))};
        seq_len = 1;
      end else begin
        seq[0] = 8'($urandom_range(255));
        seq_len = 1;
      end

      eot = ($urandom_range(5) == 0) || (sent_random + seq_len >= NumRandom);
      cut_len = seq_len;
      if (eot && seq_len > 1 && $urandom_range(2) == 0) begin
        cut_len = $urandom_range(seq_len - 1, 1);
      end
      for (int j = 0; j < cut_len; j++) begin
        send_predicted(seq[j], eot && j == cut_len - 1);
        sent_random++;
      end
    end

    s_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d bytes in %0d texts; checked %0d hex characters.",
             bytes_sent, texts_ended, chars_checked);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
